[design/lhs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package lhs_pkg;

  localparam int GRAD_W = 32;
  localparam int DIST_W = 32;
  localparam int IDX_W  = 12;

  typedef logic signed [GRAD_W-1:0] grad_t;
  typedef logic [DIST_W-1:0]        dist_t;
  typedef logic [IDX_W-1:0]         idx_t;

  localparam idx_t  CNT_MAX     = '1;
  localparam grad_t FLOOR_RESET = {1'b1, {(GRAD_W-1){1'b0}}};

  typedef struct packed {
    grad_t gradient;
    dist_t distance;
    dist_t target_distance;
    idx_t  target_node;
    logic  first;
    logic  last;
  } in_word_t;

  typedef struct packed {
    grad_t max_gradient;
    idx_t  max_gradient_index;
    grad_t max_before_target;
    idx_t  max_before_index;
    idx_t  horizon_index;
    idx_t  horizon_count;
    idx_t  horizon_before_index;
    idx_t  horizon_before_count;
    logic  target_is_horizon;
  } out_word_t;

endpackage

`default_nettype wire

[design/lhs_scan_core.sv]
`timescale 1ns / 1ps
`default_nettype none

module lhs_scan_core #(
  parameter int MAX_NODES = 4096
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 cfg_wr_en,
  input  lhs_pkg::grad_t      cfg_wr_data,
  input  wire                 step,
  input  lhs_pkg::in_word_t   item,
  output lhs_pkg::out_word_t  summary
);

  localparam int CNT_W = (MAX_NODES > 2) ? $clog2(MAX_NODES) : 1;

  typedef logic [CNT_W-1:0] cnt_t;

  lhs_pkg::grad_t floor_r;
  lhs_pkg::grad_t pend_grad_r, pend_grad_nxt;
  logic           pend_valid_r, pend_valid_nxt;
  cnt_t           pend_idx_r, pend_idx_nxt;
  cnt_t           cnt_r, cnt_nxt;
  lhs_pkg::grad_t rmax_r, rmax_nxt;
  lhs_pkg::grad_t rmaxb_r, rmaxb_nxt;
  lhs_pkg::grad_t pmax_r, pmax_nxt;
  lhs_pkg::grad_t pmaxb_r, pmaxb_nxt;
  lhs_pkg::dist_t tdist_r, tdist_nxt;
  lhs_pkg::idx_t  tnode_r, tnode_nxt;
  lhs_pkg::idx_t  maxi_r, maxi_nxt;
  lhs_pkg::idx_t  befi_r, befi_nxt;
  lhs_pkg::idx_t  hori_r, hori_nxt;
  lhs_pkg::idx_t  horc_r, horc_nxt;
  lhs_pkg::idx_t  hbi_r, hbi_nxt;
  lhs_pkg::idx_t  hbc_r, hbc_nxt;
  logic           tflag_r, tflag_nxt;

  lhs_pkg::grad_t g;
  lhs_pkg::dist_t d;
  lhs_pkg::grad_t e_rmax, e_rmaxb;
  lhs_pkg::idx_t  e_maxi, e_befi, e_hori, e_horc, e_hbi, e_hbc;
  logic           e_pend, e_tflag;
  cnt_t           e_cnt;
  lhs_pkg::idx_t  pidx12;
  lhs_pkg::idx_t  cidx12;
  logic           peak, hb;

  always_comb begin
    g       = item.gradient;
    d       = item.distance;
    e_rmax  = item.first ? floor_r : rmax_r;
    e_rmaxb = item.first ? floor_r : rmaxb_r;
    e_maxi  = item.first ? '0 : maxi_r;
    e_befi  = item.first ? '0 : befi_r;
    e_hori  = item.first ? '0 : hori_r;
    e_horc  = item.first ? '0 : horc_r;
    e_hbi   = item.first ? '0 : hbi_r;
    e_hbc   = item.first ? '0 : hbc_r;
    e_tflag = item.first ? 1'b0 : tflag_r;
    e_pend  = item.first ? 1'b0 : pend_valid_r;
    e_cnt   = item.first ? '0 : cnt_r;
    tdist_nxt = item.first ? item.target_distance : tdist_r;
    tnode_nxt = item.first ? item.target_node : tnode_r;

    pidx12 = lhs_pkg::idx_t'(pend_idx_r);
    cidx12 = lhs_pkg::idx_t'(e_cnt);
    peak   = e_pend && (g < pend_grad_r);
    hb     = peak && (pmaxb_r < pend_grad_r);

    tflag_nxt = e_tflag || (hb && (pidx12 == tnode_nxt));
    hbi_nxt   = e_hbi;
    hbc_nxt   = e_hbc;
    if (hb && (d <= tdist_nxt)) begin
      hbi_nxt = pidx12;
      hbc_nxt = (e_hbc == lhs_pkg::CNT_MAX) ? e_hbc : e_hbc + 1'b1;
    end
    hori_nxt = e_hori;
    horc_nxt = e_horc;
    if (peak && (pmax_r < pend_grad_r)) begin
      hori_nxt = pidx12;
      horc_nxt = (e_horc == lhs_pkg::CNT_MAX) ? e_horc : e_horc + 1'b1;
    end

    pmax_nxt  = e_rmax;
    pmaxb_nxt = e_rmaxb;
    rmaxb_nxt = e_rmaxb;
    befi_nxt  = e_befi;
    if ((d < tdist_nxt) && (e_rmaxb < g)) begin
      rmaxb_nxt = g;
      befi_nxt  = cidx12;
    end
    rmax_nxt = e_rmax;
    maxi_nxt = e_maxi;
    if (e_rmax < g) begin
      rmax_nxt = g;
      maxi_nxt = cidx12;
    end

    pend_grad_nxt  = g;
    pend_idx_nxt   = e_cnt;
    pend_valid_nxt = !item.last;
    cnt_nxt        = (e_cnt == cnt_t'(MAX_NODES - 1)) ? '0 : e_cnt + 1'b1;
  end

  always_comb begin
    summary.max_gradient         = rmax_nxt;
    summary.max_gradient_index   = maxi_nxt;
    summary.max_before_target    = rmaxb_nxt;
    summary.max_before_index     = befi_nxt;
    summary.horizon_index        = hori_nxt;
    summary.horizon_count        = horc_nxt;
    summary.horizon_before_index = hbi_nxt;
    summary.horizon_before_count = hbc_nxt;
    summary.target_is_horizon    = tflag_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      floor_r      <= lhs_pkg::FLOOR_RESET;
      pend_grad_r  <= '0;
      pend_valid_r <= 1'b0;
      pend_idx_r   <= '0;
      cnt_r        <= '0;
      rmax_r       <= lhs_pkg::FLOOR_RESET;
      rmaxb_r      <= lhs_pkg::FLOOR_RESET;
      pmax_r       <= lhs_pkg::FLOOR_RESET;
      pmaxb_r      <= lhs_pkg::FLOOR_RESET;
      tdist_r      <= '0;
      tnode_r      <= '0;
      maxi_r       <= '0;
      befi_r       <= '0;
      hori_r       <= '0;
      horc_r       <= '0;
      hbi_r        <= '0;
      hbc_r        <= '0;
      tflag_r      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        floor_r <= cfg_wr_data;
      end
      if (step) begin
        pend_grad_r  <= pend_grad_nxt;
        pend_valid_r <= pend_valid_nxt;
        pend_idx_r   <= pend_idx_nxt;
        cnt_r        <= cnt_nxt;
        rmax_r       <= rmax_nxt;
        rmaxb_r      <= rmaxb_nxt;
        pmax_r       <= pmax_nxt;
        pmaxb_r      <= pmaxb_nxt;
        tdist_r      <= tdist_nxt;
        tnode_r      <= tnode_nxt;
        maxi_r       <= maxi_nxt;
        befi_r       <= befi_nxt;
        hori_r       <= hori_nxt;
        horc_r       <= horc_nxt;
        hbi_r        <= hbi_nxt;
        hbc_r        <= hbc_nxt;
        tflag_r      <= tflag_nxt;
      end
    end
  end

`ifndef SYNTHESIS
  a_max_order: assert property (@(posedge clk) disable iff (!rst_n)
    (rmaxb_r <= rmax_r) && (pmaxb_r <= pmax_r))
    else $error("maximum before target exceeds overall maximum");
  a_prior_order: assert property (@(posedge clk) disable iff (!rst_n)
    (pmax_r <= rmax_r) && (pmaxb_r <= rmaxb_r))
    else $error("prior maximum exceeds running maximum");
  a_count_index: assert property (@(posedge clk) disable iff (!rst_n)
    ((hbc_r != '0) || (hbi_r == '0)) && ((horc_r != '0) || (hori_r == '0)))
    else $error("horizon index set with no horizon counted");
`endif

endmodule

`default_nettype wire

[design/lhs_out_stage.sv]
`timescale 1ns / 1ps
`default_nettype none

module lhs_out_stage (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 load,
  input  lhs_pkg::out_word_t  load_word,
  output logic                can_load,
  output logic                out_valid,
  input  wire                 out_ready,
  output lhs_pkg::out_word_t  out_word
);

  logic               valid_r, valid_nxt;
  lhs_pkg::out_word_t word_r;

  assign can_load  = !valid_r || out_ready;
  assign valid_nxt = load || (valid_r && !out_ready);
  assign out_valid = valid_r;
  assign out_word  = word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      word_r <= load_word;
    end
  end

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> can_load)
    else $error("summary loaded over an untaken summary");
`endif

endmodule

`default_nettype wire

[design/los_horizon_scan.sv]
// Horizon scan along one line of sight.
// Input channel in_valid/in_ready/in_word carries one node per word, in order
// along the line. A word with first set starts a new line and latches the
// target distance and target node index. A word with last set ends the line
// and produces one summary word on out_valid/out_ready/out_word.
// The gradient floor register is written through cfg_wr_en/cfg_wr_data and is
// used by the next line that starts; write it only while the block is idle.
// A word accepted into the input register is scanned from there into the state
// registers; when it is a last word, its summary is loaded into the output
// register by that same scan step and presented from there.
// Throughput: one node per cycle while no last word waits for the output
// register; a single scan step lies between input and state registers.
// When the receiver stalls, non-last words keep flowing; a last word waits in
// the input register until the output register is free, and in_ready then
// drops only while that word is held.
// Synchronous reset clears all line state, sets the gradient floor to the
// most negative value and empties both registers.
`timescale 1ns / 1ps
`default_nettype none

module los_horizon_scan #(
  parameter int MAX_NODES = 4096
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  lhs_pkg::in_word_t   in_word,
  output logic                out_valid,
  input  wire                 out_ready,
  output lhs_pkg::out_word_t  out_word,
  input  wire                 cfg_wr_en,
  input  lhs_pkg::grad_t      cfg_wr_data
);

  logic               s1_valid_r, s1_valid_nxt;
  lhs_pkg::in_word_t  s1_word_r;
  logic               can_load;
  logic               step;
  logic               accept;
  lhs_pkg::out_word_t summary;

  assign step         = s1_valid_r && (!s1_word_r.last || can_load);
  assign in_ready     = !s1_valid_r || step;
  assign accept       = in_valid && in_ready;
  assign s1_valid_nxt = accept || (s1_valid_r && !step);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_word_r <= in_word;
    end
  end

  lhs_scan_core #(
    .MAX_NODES (MAX_NODES)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .step        (step),
    .item        (s1_word_r),
    .summary     (summary)
  );

  lhs_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step && s1_word_r.last),
    .load_word (summary),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

`ifndef SYNTHESIS
  a_stall_reason: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && s1_word_r.last && out_valid && !out_ready))
    else $error("input stalled without a blocked summary");
  a_held_word: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !step) |=> (s1_valid_r && $stable(s1_word_r)))
    else $error("held input word lost or changed");
`endif

endmodule

`default_nettype wire
